// File: rtl/rwa_pkg.sv
// Shared types and fixed constants of the running window average block.
package rwa_pkg;

  // Width and reset value of the window length register.
  localparam int unsigned WL_BITS = 6;
  localparam logic [WL_BITS-1:0] WL_RESET = 6'd20;

  // Sequencer states of the top level.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_ADD  = 6'b000100,
    S_LOAD = 6'b001000,
    S_DIV  = 6'b010000,
    S_HOLD = 6'b100000
  } rwa_state_e;

  // Status of the bit-serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/rwa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rwa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rwa_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle, dividend MSB first.
module rwa_sdiv
  import rwa_pkg::*;
#(
  parameter int unsigned DIVIDEND_BITS = 37,
  parameter int unsigned DIVISOR_BITS  = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DIVIDEND_BITS-1:0] dividend_i,
  input  logic [DIVISOR_BITS-1:0]  divisor_i,
  output logic [DIVIDEND_BITS-1:0] quotient_o,
  output div_stat_t                stat_o
);

  localparam int unsigned CW = $clog2(DIVIDEND_BITS);

  logic [DIVIDEND_BITS-1:0] dvd_q, dvd_d;
  logic [DIVISOR_BITS-1:0]  divisor_q;
  logic [DIVISOR_BITS-1:0]  rem_q, rem_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;
  logic                     ge;

  // The partial remainder stays below the divisor, so the subtractor is only
  // one bit wider than the divisor no matter how wide the dividend is.
  assign trial = {rem_q, dvd_q[DIVIDEND_BITS-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign ge    = trial >= {1'b0, divisor_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(DIVIDEND_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIVIDEND_BITS-2:0], ge};
      rem_d = ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  assign quotient_o  = dvd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && $past(cnt_q) == '0)
    else $error("divider done without finishing its steps");

endmodule

// File: rtl/running_window_average.sv
// Running window average: mean of the last window_length signed samples.
// Input channel: in_valid_i / in_stall_o carry one sample_i word per
// transfer. Output channel: out_valid_o / out_stall_i carry one average_o
// word per accepted sample, the window sum divided by the number of samples
// held, truncated toward zero. Configuration channel: cfg_valid_i /
// cfg_ready_o write window_length_i; a write clears the history.
// Sequence: after a sample is accepted, S_READ reads the oldest entry, S_ADD
// updates the running sum and S_LOAD loads the divider, which then works
// through the bits of the running sum one at a time (SAMPLE_BITS plus
// log2(WINDOW_MAX) bits, 37 for the defaults); S_DIV sees it finish and
// S_HOLD loads the output register. The next sample is taken only once the
// sequencer is back in S_IDLE.
// A finished result waits in the output register while the receiver
// stalls; the block takes the next sample meanwhile and only holds its
// next result back until the register is free.
// Reset clears the history, running sum, write position and fill count and
// sets window_length to 20. No clearing pass runs: entries not yet written
// since the last clear read as zero by way of the fill count.
module running_window_average
  import rwa_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 32,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [WL_BITS-1:0]            window_length_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] average_o
);

  localparam int unsigned ADDR_BITS = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_BITS  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_BITS  = SAMPLE_BITS + ADDR_BITS;
  localparam int unsigned EXT_BITS  = (CNT_BITS > WL_BITS) ? CNT_BITS : WL_BITS;

  rwa_state_e state_q, state_d;

  logic [WL_BITS-1:0]            wl_q;
  logic [ADDR_BITS-1:0]          pos_q, pos_d;
  logic [CNT_BITS-1:0]           fill_q, fill_d;
  logic signed [SUM_BITS-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          sign_q;
  logic signed [SAMPLE_BITS-1:0] average_q;
  logic                          out_valid_q, out_valid_d;

  logic [EXT_BITS-1:0]    wl_ext;
  logic [CNT_BITS-1:0]    w_eff;
  logic                   cfg_write;
  logic                   in_accept;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] old_word;
  logic [SUM_BITS-1:0]    sum_mag;
  logic [SUM_BITS-1:0]    quotient;
  logic [SUM_BITS-1:0]    signed_q;
  logic                   div_start;
  div_stat_t              div_stat;

  // A window of zero acts as one, and one above WINDOW_MAX as WINDOW_MAX.
  assign wl_ext = EXT_BITS'(wl_q);
  always_comb begin
    if (wl_q == '0) begin
      w_eff = CNT_BITS'(1);
    end else if (wl_ext > EXT_BITS'(WINDOW_MAX)) begin
      w_eff = CNT_BITS'(WINDOW_MAX);
    end else begin
      w_eff = CNT_BITS'(wl_ext);
    end
  end

  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  rwa_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WINDOW_MAX)
  ) u_history (
    .clk_i  (clk_i),
    .we_i   (state_q == S_READ),
    .waddr_i(pos_q),
    .wdata_i(sample_q),
    .raddr_i(pos_q),
    .rdata_o(ram_rdata)
  );

  // Writes start at entry zero after every clear, so the entry under the
  // write position holds a sample only once the ring has filled.
  assign old_word = (fill_q == w_eff) ? ram_rdata : '0;

  assign sum_mag = sum_q[SUM_BITS-1] ? (~sum_q + 1'b1) : sum_q;

  rwa_sdiv #(
    .DIVIDEND_BITS(SUM_BITS),
    .DIVISOR_BITS (CNT_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_mag),
    .divisor_i (fill_q),
    .quotient_o(quotient),
    .stat_o    (div_stat)
  );

  assign signed_q = sign_q ? (~quotient + 1'b1) : quotient;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (cfg_write) begin
          pos_d  = '0;
          fill_d = '0;
          sum_d  = '0;
        end else if (in_accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        sum_d   = sum_q - SUM_BITS'($signed(old_word));
        state_d = S_ADD;
      end
      S_ADD: begin
        sum_d = sum_q + SUM_BITS'(sample_q);
        if (CNT_BITS'(pos_q) + 1'b1 >= w_eff) begin
          pos_d = '0;
        end else begin
          pos_d = pos_q + 1'b1;
        end
        if (fill_q < w_eff) begin
          fill_d = fill_q + 1'b1;
        end
        state_d = S_LOAD;
      end
      S_LOAD: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wl_q        <= WL_RESET;
      pos_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_write) begin
        wl_q <= window_length_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
    end
    if (state_q == S_LOAD) begin
      sign_q <= sum_q[SUM_BITS-1];
    end
    if (state_q == S_HOLD && out_free) begin
      average_q <= signed_q[SAMPLE_BITS-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;

  a_fill_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= w_eff)
    else $error("fill count beyond the window");

  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_BITS'(pos_q) < w_eff)
    else $error("write position beyond the window");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_READ)
    else $error("accepted word did not start processing");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_result_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_HOLD))
    else $error("output word loaded outside the hold state");

endmodule
